/* rtl/rhsv_pkg.sv */
// shared types and constants for the rgb to hsv pixel converter
package rhsv_pkg;

    // field widths
    localparam int COMP_W = 8;   // one colour component and v
    localparam int FRAC_W = 16;  // hue and saturation fractions
    localparam int HUE_W  = 11;  // 6c and the wrapped hue numerator
    localparam int DIFF_W = 10;  // signed difference of two components
    localparam int NUM_W  = 12;  // signed hue numerator before the wrap

    // quotient bits resolved by each divider stage, must divide FRAC_W
    localparam int DIV_BITS_PER_STAGE = 2;

    // register stages in the front end ahead of the dividers
    localparam int FRONT_STAGES = 2;

    // which component holds the maximum, ties resolved red, green, blue
    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    // operands handed from the front end to the two dividers
    typedef struct packed {
        logic [COMP_W-1:0] sat_rem;  // top byte of c*65535, below v
        logic [FRAC_W-1:0] sat_low;  // low bits of c*65535
        logic [COMP_W-1:0] value;    // v, also the saturation divisor
        logic              v_zero;   // black pixel
        logic [HUE_W-1:0]  hue_num;  // wrapped numerator, below 6c
        logic [HUE_W-1:0]  hue_dvs;  // 6c
        logic              c_zero;   // grey pixel
        logic              last;
    } t_front;

endpackage

/* rtl/rgb_to_hsv_pixel.sv */
// top level of the rgb to hsv pixel converter
//
//  port group      dir  timing            contents
//  start / busy    in   start & !busy     i_red, i_green, i_blue, i_last_pixel
//  o_strobe        out  one cycle pulse   o_hue, o_saturation, o_value, o_last_out
//
// one pixel per clock; each transaction passes through the two front stages and
// then the divider stages before its result comes out.
// busy is always low: the pipeline never stops and the receiver cannot stall.
// synchronous active low reset clears the valid bits only; results in flight
// at reset are dropped.
module rgb_to_hsv_pixel #(
    parameter int DIV_BITS = rhsv_pkg::DIV_BITS_PER_STAGE
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [rhsv_pkg::COMP_W-1:0]  i_red,
    input  logic [rhsv_pkg::COMP_W-1:0]  i_green,
    input  logic [rhsv_pkg::COMP_W-1:0]  i_blue,
    input  logic                         i_last_pixel,
    output logic                         o_strobe,
    output logic [rhsv_pkg::FRAC_W-1:0]  o_hue,
    output logic [rhsv_pkg::FRAC_W-1:0]  o_saturation,
    output logic [rhsv_pkg::COMP_W-1:0]  o_value,
    output logic                         o_last_out
);

    localparam int LATENCY = rhsv_pkg::FRONT_STAGES + rhsv_pkg::FRAC_W / DIV_BITS;

    logic             w_front_vld;
    rhsv_pkg::t_front w_req;
    logic             w_sat_vld;
    logic             w_hue_vld;

    // pipeline takes a transaction every cycle
    assign busy = 1'b0;

    rhsv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start && !busy),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .i_last  (i_last_pixel),
        .o_vld   (w_front_vld),
        .o_req   (w_req)
    );

    // saturation: c*65535 / v, v travels alongside
    rhsv_div #(
        .DVS_W  (rhsv_pkg::COMP_W),
        .Q_W    (rhsv_pkg::FRAC_W),
        .STEP   (DIV_BITS),
        .SIDE_W (rhsv_pkg::COMP_W)
    ) u_div_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_front_vld),
        .i_rem   (w_req.sat_rem),
        .i_low   (w_req.sat_low),
        .i_dvs   (w_req.value),
        .i_zero  (w_req.v_zero),
        .i_side  (w_req.value),
        .o_vld   (w_sat_vld),
        .o_quo   (o_saturation),
        .o_side  (o_value)
    );

    // hue: num*65536 / 6c, last flag travels alongside
    rhsv_div #(
        .DVS_W  (rhsv_pkg::HUE_W),
        .Q_W    (rhsv_pkg::FRAC_W),
        .STEP   (DIV_BITS),
        .SIDE_W (1)
    ) u_div_hue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_front_vld),
        .i_rem   (w_req.hue_num),
        .i_low   ('0),
        .i_dvs   (w_req.hue_dvs),
        .i_zero  (w_req.c_zero),
        .i_side  (w_req.last),
        .o_vld   (w_hue_vld),
        .o_quo   (o_hue),
        .o_side  (o_last_out)
    );

    assign o_strobe = w_sat_vld;

    // both divider lanes stay in step
    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sat_vld == w_hue_vld)
        else $error("divider lanes out of step");

    // every accepted transaction gives one result after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_strobe)
        else $error("result missing after latency");

    // black pixel has zero saturation and hue
    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_value == '0) |-> (o_saturation == '0 && o_hue == '0))
        else $error("black pixel with non-zero hue or saturation");

    // zero saturation only for grey, where hue is zero too
    a_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_saturation == '0) |-> (o_hue == '0))
        else $error("grey pixel with non-zero hue");

endmodule

/* rtl/rhsv_front.sv */
// front end: max, min, sector choice, then chroma and divider operands
module rhsv_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_vld,
    input  logic [rhsv_pkg::COMP_W-1:0]   i_red,
    input  logic [rhsv_pkg::COMP_W-1:0]   i_green,
    input  logic [rhsv_pkg::COMP_W-1:0]   i_blue,
    input  logic                          i_last,
    output logic                          o_vld,
    output rhsv_pkg::t_front              o_req
);

    // stage a registers
    logic                         r_a_vld;
    logic [rhsv_pkg::COMP_W-1:0]  r_a_red, r_a_green, r_a_blue;
    logic [rhsv_pkg::COMP_W-1:0]  r_a_max, r_a_min;
    rhsv_pkg::t_sector            r_a_sec;
    logic                         r_a_last;

    logic [rhsv_pkg::COMP_W-1:0]  n_a_max, n_a_min;
    rhsv_pkg::t_sector            n_a_sec;

    // stage b registers
    logic                         r_b_vld;
    rhsv_pkg::t_front             r_b;
    rhsv_pkg::t_front             n_b;

    logic [rhsv_pkg::COMP_W-1:0]  w_c;
    logic [rhsv_pkg::HUE_W-1:0]   w_base;
    logic [rhsv_pkg::HUE_W-1:0]   w_six_c;
    logic signed [rhsv_pkg::DIFF_W-1:0] w_diff;
    logic signed [rhsv_pkg::NUM_W-1:0]  w_num;
    logic signed [rhsv_pkg::NUM_W-1:0]  w_num_wrap;
    logic [rhsv_pkg::COMP_W+rhsv_pkg::FRAC_W-1:0] w_sat_dvd;

    // largest and smallest component, sector by priority
    always_comb begin
        n_a_max = (i_red > i_green) ? i_red : i_green;
        n_a_max = (n_a_max > i_blue) ? n_a_max : i_blue;
        n_a_min = (i_red < i_green) ? i_red : i_green;
        n_a_min = (n_a_min < i_blue) ? n_a_min : i_blue;
        if (n_a_max == i_red) begin
            n_a_sec = rhsv_pkg::SEC_RED;
        end else if (n_a_max == i_green) begin
            n_a_sec = rhsv_pkg::SEC_GREEN;
        end else begin
            n_a_sec = rhsv_pkg::SEC_BLUE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_red   <= i_red;
        r_a_green <= i_green;
        r_a_blue  <= i_blue;
        r_a_max   <= n_a_max;
        r_a_min   <= n_a_min;
        r_a_sec   <= n_a_sec;
        r_a_last  <= i_last;
    end

    // chroma, signed hue numerator and its wrap into [0, 6c)
    always_comb begin
        w_c     = r_a_max - r_a_min;
        w_six_c = {1'b0, w_c, 2'b00} + {2'b00, w_c, 1'b0};
        case (r_a_sec)
            rhsv_pkg::SEC_RED: begin
                w_base = '0;
                w_diff = $signed({2'b00, r_a_green}) - $signed({2'b00, r_a_blue});
            end
            rhsv_pkg::SEC_GREEN: begin
                w_base = {2'b00, w_c, 1'b0};
                w_diff = $signed({2'b00, r_a_blue}) - $signed({2'b00, r_a_red});
            end
            rhsv_pkg::SEC_BLUE: begin
                w_base = {1'b0, w_c, 2'b00};
                w_diff = $signed({2'b00, r_a_red}) - $signed({2'b00, r_a_green});
            end
            default: begin
                w_base = '0;
                w_diff = '0;
            end
        endcase
        w_num      = $signed({1'b0, w_base}) + $signed({{2{w_diff[rhsv_pkg::DIFF_W-1]}}, w_diff});
        w_num_wrap = w_num[rhsv_pkg::NUM_W-1] ? (w_num + $signed({1'b0, w_six_c})) : w_num;
        // c*65535 as c*65536 - c
        w_sat_dvd  = {w_c, {rhsv_pkg::FRAC_W{1'b0}}} - {{rhsv_pkg::FRAC_W{1'b0}}, w_c};

        n_b.sat_rem = w_sat_dvd[rhsv_pkg::COMP_W+rhsv_pkg::FRAC_W-1:rhsv_pkg::FRAC_W];
        n_b.sat_low = w_sat_dvd[rhsv_pkg::FRAC_W-1:0];
        n_b.value   = r_a_max;
        n_b.v_zero  = (r_a_max == '0);
        n_b.hue_num = w_num_wrap[rhsv_pkg::HUE_W-1:0];
        n_b.hue_dvs = w_six_c;
        n_b.c_zero  = (w_c == '0);
        n_b.last    = r_a_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b <= n_b;
    end

    assign o_vld = r_b_vld;
    assign o_req = r_b;

endmodule

/* rtl/rhsv_div.sv */
// pipelined restoring divider, STEP quotient bits per stage
module rhsv_div #(
    parameter int DVS_W  = 8,
    parameter int Q_W    = 16,
    parameter int STEP   = 2,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [DVS_W-1:0]  i_rem,     // upper dividend part, below divisor
    input  logic [Q_W-1:0]    i_low,     // lower dividend bits, msb first
    input  logic [DVS_W-1:0]  i_dvs,
    input  logic              i_zero,    // force a zero quotient
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_vld,
    output logic [Q_W-1:0]    o_quo,
    output logic [SIDE_W-1:0] o_side
);

    localparam int NSTG = Q_W / STEP;

    logic              r_vld  [NSTG];
    logic [DVS_W-1:0]  r_rem  [NSTG];
    logic [Q_W-1:0]    r_low  [NSTG];
    logic [Q_W-1:0]    r_quo  [NSTG];
    logic [DVS_W-1:0]  r_dvs  [NSTG];
    logic              r_zero [NSTG];
    logic [SIDE_W-1:0] r_side [NSTG];

    for (genvar s = 0; s < NSTG; s++) begin : g_stg
        logic              w_vld;
        logic [DVS_W-1:0]  w_rem_in;
        logic [Q_W-1:0]    w_low_in;
        logic [Q_W-1:0]    w_quo_in;
        logic [DVS_W-1:0]  w_dvs;
        logic              w_zero;
        logic [SIDE_W-1:0] w_side;
        logic [DVS_W-1:0]  n_rem;
        logic [Q_W-1:0]    n_low;
        logic [Q_W-1:0]    n_quo;
        logic [DVS_W:0]    w_ext;

        // stage input from the ports or the previous stage
        if (s == 0) begin : g_first
            assign w_vld    = i_vld;
            assign w_rem_in = i_rem;
            assign w_low_in = i_low;
            assign w_quo_in = '0;
            assign w_dvs    = i_dvs;
            assign w_zero   = i_zero;
            assign w_side   = i_side;
        end else begin : g_next
            assign w_vld    = r_vld[s-1];
            assign w_rem_in = r_rem[s-1];
            assign w_low_in = r_low[s-1];
            assign w_quo_in = r_quo[s-1];
            assign w_dvs    = r_dvs[s-1];
            assign w_zero   = r_zero[s-1];
            assign w_side   = r_side[s-1];
        end

        // shift in one dividend bit, trial subtract, one quotient bit per step
        always_comb begin
            n_rem = w_rem_in;
            n_low = w_low_in;
            n_quo = w_quo_in;
            w_ext = '0;
            for (int k = 0; k < STEP; k++) begin
                w_ext = {n_rem, n_low[Q_W-1]};
                n_low = {n_low[Q_W-2:0], 1'b0};
                if (w_ext >= {1'b0, w_dvs}) begin
                    w_ext = w_ext - {1'b0, w_dvs};
                    n_quo = {n_quo[Q_W-2:0], 1'b1};
                end else begin
                    n_quo = {n_quo[Q_W-2:0], 1'b0};
                end
                n_rem = w_ext[DVS_W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[s]  <= n_rem;
            r_low[s]  <= n_low;
            r_quo[s]  <= n_quo;
            r_dvs[s]  <= w_dvs;
            r_zero[s] <= w_zero;
            r_side[s] <= w_side;
        end
    end

    assign o_vld  = r_vld[NSTG-1];
    assign o_quo  = r_zero[NSTG-1] ? '0 : r_quo[NSTG-1];
    assign o_side = r_side[NSTG-1];

endmodule

/* test/rgb_to_hsv_pixel_checker.sv */
// checker for the rgb to hsv pixel converter: watches both ports, predicts and compares
`timescale 1ns / 1ps

module rgb_to_hsv_pixel_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_busy,
    input  logic [rhsv_pkg::COMP_W-1:0]  i_red,
    input  logic [rhsv_pkg::COMP_W-1:0]  i_green,
    input  logic [rhsv_pkg::COMP_W-1:0]  i_blue,
    input  logic                         i_last_pixel,
    input  logic                         i_strobe,
    input  logic [rhsv_pkg::FRAC_W-1:0]  i_hue,
    input  logic [rhsv_pkg::FRAC_W-1:0]  i_saturation,
    input  logic [rhsv_pkg::COMP_W-1:0]  i_value,
    input  logic                         i_last_out,
    output int                           o_fail_count,
    output int                           o_pending
);

    typedef struct packed {
        logic [rhsv_pkg::FRAC_W-1:0] hue;
        logic [rhsv_pkg::FRAC_W-1:0] sat;
        logic [rhsv_pkg::COMP_W-1:0] value;
        logic                        last;
    } t_hsv;

    t_hsv hsv_queue[$];
    int   fail_count  = 0;
    int   pending_cnt = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_cnt;

    // hsv of one pixel: sector picked red, green, blue on ties, numerator wrapped into [0, 6c)
    function automatic t_hsv predict_hsv(input logic [rhsv_pkg::COMP_W-1:0] r,
                                         input logic [rhsv_pkg::COMP_W-1:0] g,
                                         input logic [rhsv_pkg::COMP_W-1:0] b,
                                         input logic last);
        t_hsv              res;
        int                v;
        int                mn;
        int                c;
        int                num;
        rhsv_pkg::t_sector sec;
        v  = (r > g) ? int'(r) : int'(g);
        v  = (int'(b) > v) ? int'(b) : v;
        mn = (r < g) ? int'(r) : int'(g);
        mn = (int'(b) < mn) ? int'(b) : mn;
        c  = v - mn;
        res.value = v[rhsv_pkg::COMP_W-1:0];
        res.last  = last;
        res.sat   = (v == 0) ? '0 : rhsv_pkg::FRAC_W'((c * 65535) / v);
        res.hue   = '0;
        if (c != 0) begin
            if (v == int'(r))
                sec = rhsv_pkg::SEC_RED;
            else if (v == int'(g))
                sec = rhsv_pkg::SEC_GREEN;
            else
                sec = rhsv_pkg::SEC_BLUE;
            case (sec)
                rhsv_pkg::SEC_RED:   num = int'(g) - int'(b);
                rhsv_pkg::SEC_GREEN: num = 2 * c + (int'(b) - int'(r));
                default:             num = 4 * c + (int'(r) - int'(g));
            endcase
            if (num < 0)
                num += 6 * c;
            res.hue = rhsv_pkg::FRAC_W'((num * 65536) / (6 * c));
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    // record each input transaction, check each result against the oldest prediction
    always @(posedge i_clk) begin
        t_hsv want;
        if (i_rst_n) begin
            if (i_start && !i_busy)
                hsv_queue.push_back(predict_hsv(i_red, i_green, i_blue, i_last_pixel));
            if (i_strobe) begin
                if (hsv_queue.size() == 0) begin
                    report_mismatch("unexpected result, hue", int'(i_hue), 0);
                end else begin
                    want = hsv_queue.pop_front();
                    if (i_hue !== want.hue)
                        report_mismatch("hue", int'(i_hue), int'(want.hue));
                    if (i_saturation !== want.sat)
                        report_mismatch("saturation", int'(i_saturation), int'(want.sat));
                    if (i_value !== want.value)
                        report_mismatch("value", int'(i_value), int'(want.value));
                    if (i_last_out !== want.last)
                        report_mismatch("last_out", int'(i_last_out), int'(want.last));
                end
            end
        end
        pending_cnt <= hsv_queue.size();
    end

endmodule

/* test/testbench.sv */
// testbench top for the rgb to hsv pixel converter: stimulus, watchdog and verdict
`timescale 1ns / 1ps

module testbench;

    localparam int LATENCY    = 10;
    localparam int IDLE_LIMIT = 500;
    localparam int PHASE_LEN  = 350;

    logic                        i_clk;
    logic                        i_rst_n      = 1'b0;
    logic                        start        = 1'b0;
    logic                        busy;
    logic [rhsv_pkg::COMP_W-1:0] i_red        = '0;
    logic [rhsv_pkg::COMP_W-1:0] i_green      = '0;
    logic [rhsv_pkg::COMP_W-1:0] i_blue       = '0;
    logic                        i_last_pixel = 1'b0;
    logic                        o_strobe;
    logic [rhsv_pkg::FRAC_W-1:0] o_hue;
    logic [rhsv_pkg::FRAC_W-1:0] o_saturation;
    logic [rhsv_pkg::COMP_W-1:0] o_value;
    logic                        o_last_out;
    int                          fail_count;
    int                          pending;
    int                          quiet_cycles = 0;

    rgb_to_hsv_pixel u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .i_last_pixel (i_last_pixel),
        .o_strobe     (o_strobe),
        .o_hue        (o_hue),
        .o_saturation (o_saturation),
        .o_value      (o_value),
        .o_last_out   (o_last_out)
    );

    rgb_to_hsv_pixel_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .i_last_pixel (i_last_pixel),
        .i_strobe     (o_strobe),
        .i_hue        (o_hue),
        .i_saturation (o_saturation),
        .i_value      (o_value),
        .i_last_out   (o_last_out),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog: cycles with neither an input transaction nor a result
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("[rgb_to_hsv_pixel] ERROR");
            $finish;
        end
    end

    // one pixel transaction, preceded by random idle cycles
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                              input logic last, input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start        <= 1'b1;
        i_red        <= r;
        i_green      <= g;
        i_blue       <= b;
        i_last_pixel <= last;
        // busy is settled by the falling edge, so it says whether the next edge accepts
        forever begin
            @(negedge i_clk);
            if (!busy)
                break;
            @(posedge i_clk);
        end
        @(posedge i_clk);
    endtask

    // random pixel, biased towards greys, ties and tiny components
    task automatic send_random(input int idle_pct);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] x;
        logic       last;
        r    = 8'($urandom);
        g    = 8'($urandom);
        b    = 8'($urandom);
        x    = 8'($urandom);
        last = ($urandom_range(15) == 0);
        case ($urandom_range(7))
            0: begin
                g = r;
                b = r;
            end
            1: begin
                case ($urandom_range(2))
                    0: begin r = x; g = x; end
                    1: begin g = x; b = x; end
                    default: begin r = x; b = x; end
                endcase
            end
            2: begin
                r = 8'($urandom_range(3));
                g = 8'($urandom_range(3));
                b = 8'($urandom_range(3));
            end
            default: ;
        endcase
        send_pixel(r, g, b, last, idle_pct);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: black, white, grey, primaries, ties, wrap of a negative numerator
        send_pixel(8'd0,   8'd0,   8'd0,   1'b0, 0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b1, 0);
        send_pixel(8'd128, 8'd128, 8'd128, 1'b0, 0);
        send_pixel(8'd255, 8'd0,   8'd0,   1'b0, 0);
        send_pixel(8'd0,   8'd255, 8'd0,   1'b1, 0);
        send_pixel(8'd0,   8'd0,   8'd255, 1'b0, 0);
        send_pixel(8'd255, 8'd255, 8'd0,   1'b0, 0);
        send_pixel(8'd0,   8'd255, 8'd255, 1'b0, 0);
        send_pixel(8'd255, 8'd0,   8'd255, 1'b1, 0);
        send_pixel(8'd255, 8'd0,   8'd1,   1'b0, 0);
        send_pixel(8'd200, 8'd10,  8'd200, 1'b0, 0);
        send_pixel(8'd1,   8'd0,   8'd0,   1'b0, 0);
        send_pixel(8'd0,   8'd1,   8'd0,   1'b0, 0);
        send_pixel(8'd0,   8'd0,   8'd1,   1'b1, 0);
        send_pixel(8'd255, 8'd254, 8'd254, 1'b0, 0);
        send_pixel(8'd1,   8'd1,   8'd0,   1'b0, 0);
        send_pixel(8'd0,   8'd1,   8'd1,   1'b0, 0);
        send_pixel(8'd254, 8'd255, 8'd0,   1'b0, 0);
        send_pixel(8'd0,   8'd254, 8'd255, 1'b1, 0);
        send_pixel(8'd255, 8'd1,   8'd0,   1'b0, 0);
        send_pixel(8'd170, 8'd85,  8'd255, 1'b0, 0);

        // random, in three idling phases
        repeat (PHASE_LEN) send_random(33);
        repeat (PHASE_LEN) send_random(62);
        repeat (PHASE_LEN) send_random(0);
        start <= 1'b0;

        // drain, then a few more cycles for any stray result
        do @(posedge i_clk); while (pending != 0);
        repeat (3 * LATENCY) @(posedge i_clk);

        if (fail_count == 0 && pending == 0)
            $display("[rgb_to_hsv_pixel] OK");
        else
            $display("[rgb_to_hsv_pixel] ERROR");
        $finish;
    end

endmodule
